### sv/chtis_pkg.sv
// Shared types, constants, microcode table and helper functions for the chained hash table.
package chtis_pkg;

  localparam int NUM_BUCKETS  = 16;
  localparam int BUCKET_DEPTH = 8;

  localparam int KEY_W     = 31;
  localparam int CFG_W     = 5;
  localparam int STATUS_W  = 2;
  localparam int OUT_BKT_W = 4;
  localparam int DIV_W     = CFG_W;
  localparam int CHUNK_W   = 8;
  localparam int CHUNKS    = (KEY_W + CHUNK_W - 1) / CHUNK_W;
  localparam int PAD_W     = CHUNKS * CHUNK_W;
  localparam int CNT_W     = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;

  localparam int BKT_W  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int SLOT_W = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
  localparam int FILL_W = $clog2(BUCKET_DEPTH + 1);
  localparam int MEM_DEPTH = NUM_BUCKETS * BUCKET_DEPTH;
  localparam int ADDR_W = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

  localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

  localparam int STEP_W = 3;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_IDLE   = 3'd0;
  localparam step_t STEP_DIV    = 3'd1;
  localparam step_t STEP_FILL   = 3'd2;
  localparam step_t STEP_INSERT = 3'd3;
  localparam step_t STEP_SFIRST = 3'd6;
  localparam step_t STEP_SCMP   = 3'd7;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_IDLE,
    OP_DIV,
    OP_FILL,
    OP_INSERT,
    OP_SFIRST,
    OP_SCMP
  } op_e;

  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_NOT_START,
    C_DIV_MORE,
    C_IS_SEARCH,
    C_FILL_ZERO,
    C_SRCH_MORE
  } cond_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    step_t target;
  } ctrl_t;

  typedef struct packed {
    logic div_more;
    logic is_search;
    logic fill_zero;
    logic srch_more;
  } stat_t;

  // control store; step + 1 wraps from the last search step back to idle
  function automatic ctrl_t ucode_rom(input step_t step);
    ctrl_t w;
    case (step)
      STEP_IDLE:   w = '{op: OP_IDLE,   cond: C_NOT_START, target: STEP_IDLE};
      STEP_DIV:    w = '{op: OP_DIV,    cond: C_DIV_MORE,  target: STEP_DIV};
      STEP_FILL:   w = '{op: OP_FILL,   cond: C_IS_SEARCH, target: STEP_SFIRST};
      STEP_INSERT: w = '{op: OP_INSERT, cond: C_ALWAYS,    target: STEP_IDLE};
      STEP_SFIRST: w = '{op: OP_SFIRST, cond: C_FILL_ZERO, target: STEP_IDLE};
      STEP_SCMP:   w = '{op: OP_SCMP,   cond: C_SRCH_MORE, target: STEP_SCMP};
      default:     w = '{op: OP_NOP,    cond: C_ALWAYS,    target: STEP_IDLE};
    endcase
    return w;
  endfunction

  // zero reads as one, above the table size saturates
  function automatic logic [DIV_W-1:0] clamp_div(input logic [CFG_W-1:0] cfg);
    logic [DIV_W-1:0] d;
    if (cfg == '0) begin
      d = DIV_W'(1);
    end else if (32'(cfg) > NUM_BUCKETS) begin
      d = DIV_W'(NUM_BUCKETS);
    end else begin
      d = DIV_W'(cfg);
    end
    return d;
  endfunction

  // one chunk of restoring remainder, MSB first
  function automatic logic [DIV_W-1:0] div_step(input logic [DIV_W-1:0] rem,
                                                input logic [CHUNK_W-1:0] dig,
                                                input logic [DIV_W-1:0] d);
    logic [DIV_W:0] r;
    r = {1'b0, rem};
    for (int i = CHUNK_W - 1; i >= 0; i--) begin
      r = {r[DIV_W-1:0], dig[i]};
      if (r >= {1'b0, d}) begin
        r = r - {1'b0, d};
      end
    end
    return r[DIV_W-1:0];
  endfunction

endpackage

### sv/chtis_seq.sv
// Microcode sequencer: step counter, control store lookup and conditional jumps.
module chtis_seq import chtis_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  stat_t stat_i,
  output ctrl_t ctrl_o,
  output logic  busy_o
);

  step_t step_q, step_d;
  ctrl_t ctrl;
  logic  take;

  always_comb begin
    ctrl = ucode_rom(step_q);
  end

  always_comb begin
    case (ctrl.cond)
      C_NEXT:      take = 1'b0;
      C_ALWAYS:    take = 1'b1;
      C_NOT_START: take = !start_i;
      C_DIV_MORE:  take = stat_i.div_more;
      C_IS_SEARCH: take = stat_i.is_search;
      C_FILL_ZERO: take = stat_i.fill_zero;
      C_SRCH_MORE: take = stat_i.srch_more;
      default:     take = 1'b1;
    endcase
    step_d = take ? ctrl.target : step_q + step_t'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  assign ctrl_o = ctrl;
  assign busy_o = (step_q != STEP_IDLE);

endmodule

### sv/chtis_dp.sv
// Datapath: remainder unit, fill counters, bucket key store and result register.
module chtis_dp import chtis_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ctrl_t                ctrl_i,
  input  logic                 start_i,
  input  logic                 mode_i,
  input  logic [KEY_W-1:0]     key_i,
  input  logic [CFG_W-1:0]     bucket_count_i,
  output stat_t                stat_o,
  output logic                 done_o,
  output logic [STATUS_W-1:0]  status_o,
  output logic [OUT_BKT_W-1:0] bucket_o
);

  logic [KEY_W-1:0]  key_q;
  logic              mode_q;
  logic [PAD_W-1:0]  sh_q;
  logic [DIV_W-1:0]  div_q;
  logic [DIV_W-1:0]  rem_q;
  logic [CNT_W-1:0]  dcnt_q;
  logic [BKT_W-1:0]  bkt_q;
  logic [FILL_W-1:0] cur_fill_q;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [FILL_W-1:0] fill_q [NUM_BUCKETS];

  logic [KEY_W-1:0]  mem [MEM_DEPTH];
  logic [KEY_W-1:0]  rdata_q;
  logic [ADDR_W-1:0] waddr, raddr;
  logic              we;

  logic              full, hit, last;
  logic              emit;
  logic [STATUS_W-1:0] emit_st;

  logic              done_q;
  logic [STATUS_W-1:0] status_q;
  logic [BKT_W-1:0]  bucket_q;

  assign full  = (cur_fill_q >= FILL_W'(BUCKET_DEPTH));
  assign hit   = (rdata_q == key_q);
  assign last  = ((FILL_W'(slot_q) + FILL_W'(1)) >= cur_fill_q);
  assign we    = (ctrl_i.op == OP_INSERT) && !full;
  assign waddr = ADDR_W'(32'(bkt_q) * BUCKET_DEPTH + 32'(cur_fill_q));
  assign raddr = ADDR_W'(32'(bkt_q) * BUCKET_DEPTH + 32'(slot_d));

  assign stat_o.div_more  = (dcnt_q != CNT_W'(CHUNKS - 1));
  assign stat_o.is_search = mode_q;
  assign stat_o.fill_zero = (cur_fill_q == '0);
  assign stat_o.srch_more = !hit && !last;

  always_comb begin
    case (ctrl_i.op)
      OP_SFIRST: slot_d = '0;
      OP_SCMP:   slot_d = slot_q + SLOT_W'(1);
      default:   slot_d = slot_q;
    endcase
  end

  always_comb begin
    emit    = 1'b0;
    emit_st = ST_NOT_FOUND;
    case (ctrl_i.op)
      OP_INSERT: begin
        emit    = 1'b1;
        emit_st = full ? ST_FULL : ST_INSERTED;
      end
      OP_SFIRST: begin
        emit    = (cur_fill_q == '0);
        emit_st = ST_NOT_FOUND;
      end
      OP_SCMP: begin
        emit    = hit || last;
        emit_st = hit ? ST_FOUND : ST_NOT_FOUND;
      end
      default: begin
        emit    = 1'b0;
        emit_st = ST_NOT_FOUND;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (ctrl_i.op)
      OP_IDLE: begin
        if (start_i) begin
          key_q  <= key_i;
          mode_q <= mode_i;
          sh_q   <= PAD_W'(key_i);
          div_q  <= clamp_div(bucket_count_i);
          rem_q  <= '0;
          dcnt_q <= '0;
        end
      end
      OP_DIV: begin
        rem_q  <= div_step(rem_q, sh_q[PAD_W-1 -: CHUNK_W], div_q);
        sh_q   <= sh_q << CHUNK_W;
        dcnt_q <= dcnt_q + CNT_W'(1);
      end
      OP_FILL: begin
        bkt_q      <= BKT_W'(rem_q);
        cur_fill_q <= fill_q[BKT_W'(rem_q)];
      end
      default: begin
      end
    endcase
    slot_q <= slot_d;
    if (emit) begin
      status_q <= emit_st;
      bucket_q <= bkt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_BUCKETS; i++) begin
        fill_q[i] <= '0;
      end
      done_q <= 1'b0;
    end else begin
      if (we) begin
        fill_q[bkt_q] <= cur_fill_q + FILL_W'(1);
      end
      done_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= key_q;
    end
    rdata_q <= mem[raddr];
  end

  assign done_o   = done_q;
  assign status_o = status_q;
  assign bucket_o = OUT_BKT_W'(bucket_q);

endmodule

### sv/chained_hash_table_insert_search_top.sv
// Top level of the chained hash table with insert and search.
// Steps: an insert runs remainder, fill and insert; a search runs remainder, fill, first-slot
// and compare, skipping compare on an empty bucket; done_o is registered from the last step.
// Throughput: one item at a time; busy_o stays high until the result is shown.
// The remainder unit runs 4 steps and the scan checks one slot per cycle.
// Reset clears the fill counts and sets bucket_count to 16; the result can't be stalled.
module chained_hash_table_insert_search_top import chtis_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic                 mode_i,
  input  logic [KEY_W-1:0]     key_i,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output logic                 done_o,
  output logic [STATUS_W-1:0]  status_o,
  output logic [OUT_BKT_W-1:0] bucket_o
);

  logic [CFG_W-1:0] bucket_count_q;
  ctrl_t            ctrl;
  stat_t            stat;
  logic             busy;

  assign cfg_ready_o = !busy;
  assign busy_o      = busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bucket_count_q <= CFG_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      bucket_count_q <= cfg_data_i;
    end
  end

  chtis_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .stat_i  (stat),
    .ctrl_o  (ctrl),
    .busy_o  (busy)
  );

  chtis_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .start_i        (start_i),
    .mode_i         (mode_i),
    .key_i          (key_i),
    .bucket_count_i (bucket_count_q),
    .stat_o         (stat),
    .done_o         (done_o),
    .status_o       (status_o),
    .bucket_o       (bucket_o)
  );

endmodule

### sv/chtis_chk.sv
// Port-level checker for the hash table top level, with its bind.
module chtis_chk import chtis_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 start_i,
  input logic                 busy_o,
  input logic                 cfg_ready_o,
  input logic                 done_o
);

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("busy_o not raised after a transfer");

  a_busy_from_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i))
    else $error("busy_o rose without start_i");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result shown while busy");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> !cfg_ready_o)
    else $error("config ready while busy");

endmodule

bind chained_hash_table_insert_search_top chtis_chk u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .cfg_ready_o (cfg_ready_o),
  .done_o      (done_o)
);
